/* hw/rtl/uirs_pkg.sv */
// Shared constants and types for the unique index rejection sampler.
package uirs_pkg;

    localparam int SET_SIZE = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = $clog2(SET_SIZE + 1);
    localparam int ADDR_W   = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_RANGE     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_SMALL     = 3'd3,
        ST_STARTED   = 3'd4,
        ST_IDLE      = 3'd5
    } status_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_OFFER = 1'b1
    } command_t;

    // All bits at and below the highest set bit of v.
    function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        return m;
    endfunction

endpackage

/* hw/rtl/uirs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module uirs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/unique_index_rejection_sampler.sv */
// Unique index rejection sampler: top level with control, bound register and output register.
//
// Draws SET_SIZE distinct indices below max_position from offered 32-bit random
// words (with no upper limit when the bound's top bit is set). A start transaction
// (tuser = 0) clears the selection and reports started, or bound too small when
// max_position < SET_SIZE. An offer transaction (tuser = 1) masks the word to the
// bound's bit length, rejects it when out of range, then compares it against the
// indices already chosen, which sit in a small RAM read one entry per cycle.
// Starts, idle offers, out-of-range offers and offers while no index is stored
// yet need no comparison; any other offer compares up to SET_SIZE - 1 stored
// indices in turn through the single read port of the index RAM. Each transaction
// gives exactly one result transaction; the next input is taken once the block is
// idle and the result register is free or being drained. The bound is to be
// written through cfg only while the block is idle; the block does not enforce this.
module unique_index_rejection_sampler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uirs_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [uirs_pkg::WORD_W-1:0]      s_axis_tdata,  // [31:0] random_word
    input  logic                             s_axis_tuser,  // [0] command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [uirs_pkg::WORD_W-1:0]      m_axis_tdata,  // [31:0] index
    output logic [uirs_pkg::STATUS_W-1:0]    m_axis_tuser,  // [2:0] status
    output logic                             m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [uirs_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            selecting_reg, selecting_next;
    logic [uirs_pkg::WORD_W-1:0]     max_position_reg;
    logic [uirs_pkg::WORD_W-1:0]     cand_reg, cand_next;
    logic [uirs_pkg::ADDR_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic [uirs_pkg::WORD_W-1:0]     out_index_reg, out_index_next;
    uirs_pkg::status_t               out_status_reg, out_status_next;
    logic                            out_last_reg, out_last_next;

    logic                            in_take;
    logic                            out_take;
    logic [uirs_pkg::WORD_W-1:0]     mask;
    logic [uirs_pkg::WORD_W-1:0]     cand;
    logic                            in_range;
    logic                            wr_en;
    logic [uirs_pkg::ADDR_W-1:0]     wr_addr;
    logic [uirs_pkg::WORD_W-1:0]     wr_data;
    logic [uirs_pkg::ADDR_W-1:0]     rd_addr;
    logic [uirs_pkg::WORD_W-1:0]     rd_data;
    logic [uirs_pkg::COUNT_W-1:0]    count_inc;
    logic [uirs_pkg::COUNT_W-1:0]    scan_next_cnt;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_index_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Full-width bound: word used as is, no range check.
    assign mask     = max_position_reg[uirs_pkg::WORD_W-1] ? '1
                      : uirs_pkg::smear(max_position_reg);
    assign cand     = s_axis_tdata & mask;
    assign in_range = max_position_reg[uirs_pkg::WORD_W-1] || (cand < max_position_reg);

    assign count_inc     = count_reg + uirs_pkg::COUNT_W'(1);
    assign scan_next_cnt = uirs_pkg::COUNT_W'(scan_idx_reg) + uirs_pkg::COUNT_W'(1);
    assign wr_addr       = count_reg[uirs_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        selecting_next  = selecting_reg;
        cand_next       = cand_reg;
        scan_idx_next   = scan_idx_reg;
        out_valid_next  = out_valid_reg && !out_take;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_data         = cand_reg;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    out_index_next = '0;
                    out_last_next  = 1'b0;
                    if (s_axis_tuser == uirs_pkg::CMD_START)
                    begin
                        out_valid_next = 1'b1;
                        count_next     = '0;
                        if (max_position_reg < uirs_pkg::WORD_W'(uirs_pkg::SET_SIZE))
                        begin
                            selecting_next  = 1'b0;
                            out_status_next = uirs_pkg::ST_SMALL;
                        end
                        else
                        begin
                            selecting_next  = 1'b1;
                            out_status_next = uirs_pkg::ST_STARTED;
                        end
                    end
                    else if (!selecting_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = uirs_pkg::ST_IDLE;
                    end
                    else if (!in_range)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = uirs_pkg::ST_RANGE;
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = uirs_pkg::ST_ACCEPTED;
                        out_index_next  = cand;
                        wr_en           = 1'b1;
                        wr_data         = cand;
                        count_next      = count_inc;
                        if (count_inc == uirs_pkg::COUNT_W'(uirs_pkg::SET_SIZE))
                        begin
                            out_last_next  = 1'b1;
                            selecting_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cand_next     = cand;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_addr = scan_idx_reg + uirs_pkg::ADDR_W'(1);
                if (rd_data == cand_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = uirs_pkg::ST_DUPLICATE;
                    out_index_next  = '0;
                    out_last_next   = 1'b0;
                    state_next      = S_IDLE;
                end
                else if (scan_next_cnt == count_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = uirs_pkg::ST_ACCEPTED;
                    out_index_next  = cand_reg;
                    out_last_next   = 1'b0;
                    wr_en           = 1'b1;
                    count_next      = count_inc;
                    if (count_inc == uirs_pkg::COUNT_W'(uirs_pkg::SET_SIZE))
                    begin
                        out_last_next  = 1'b1;
                        selecting_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + uirs_pkg::ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            selecting_reg    <= 1'b0;
            max_position_reg <= '1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            selecting_reg <= selecting_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_position_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg       <= cand_next;
        scan_idx_reg   <= scan_idx_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    uirs_ram #(
        .WIDTH (uirs_pkg::WORD_W),
        .DEPTH (uirs_pkg::SET_SIZE)
    ) u_chosen_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
